### hw/rtl/s5hs_pkg.sv
`default_nettype none
package s5hs_pkg;

   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned MAX_NAME_LEN = 256;

   localparam logic [31:0] BIND_RESET = 32'h7F00_0001;
   localparam logic [15:0] PORT_RESET = 16'd1080;

   typedef enum logic [1:0] {
      REQ_BYTE = 2'd0,
      REQ_LOST = 2'd1,
      REQ_NEW  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_REPLY = 2'd0,
      KIND_ADDR  = 2'd1,
      KIND_FIN   = 2'd2
   } out_kind_type;

   typedef enum logic [1:0] {
      OC_FAIL = 2'd0,
      OC_TCP  = 2'd1,
      OC_UDP  = 2'd2
   } outcome_type;

   localparam logic REG_BIND = 1'b0;
   localparam logic REG_PORT = 1'b1;

   localparam logic [7:0] SOCKS_VER     = 8'h05;
   localparam logic [7:0] METHOD_NOAUTH = 8'h00;
   localparam logic [7:0] METHOD_NONE   = 8'hFF;
   localparam logic [7:0] CMD_CONNECT   = 8'h01;
   localparam logic [7:0] CMD_UDP       = 8'h03;
   localparam logic [7:0] ATYP_IPV4     = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
   localparam logic [7:0] ATYP_IPV6     = 8'h04;
   localparam logic [7:0] REP_OK        = 8'h00;
   localparam logic [7:0] REP_BAD_CMD   = 8'h07;
   localparam logic [7:0] REP_BAD_ATYP  = 8'h08;
   localparam logic [7:0] RSV_BYTE      = 8'h00;

   localparam logic [7:0] IPV4_LEN  = 8'd4;
   localparam logic [7:0] IPV4_SKIP = 8'd6;
   localparam logic [7:0] IPV6_SKIP = 8'd18;
   localparam logic [7:0] PORT_SKIP = 8'd2;

   localparam logic [3:0] GREET_LEN = 4'd2;
   localparam logic [3:0] REPLY_LEN = 4'd10;

   // one queued job: optional reply bytes, then optionally an address byte or a finish result
   typedef struct packed {
      logic [3:0]  nrep;
      logic        has_fin;
      logic        has_addr;
      logic [7:0]  code;
      logic [31:0] addr;
      logic [15:0] rport;
      outcome_type oc;
      logic [15:0] fport;
      logic        akind;
      logic [7:0]  alen;
   } s5hs_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } s5hs_qstat_type;

endpackage
`default_nettype wire

### hw/rtl/s5hs_front.sv
`default_nettype none
module s5hs_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_type,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic [31:0]           bind_address,
   input  wire logic [15:0]           listen_port,
   input  wire s5hs_pkg::s5hs_qstat_type qstat,
   output logic                       push,
   output s5hs_pkg::s5hs_desc_type    desc
);
   import s5hs_pkg::*;

   typedef enum logic [14:0] {
      PH_GVER   = 15'h0001,
      PH_GNUM   = 15'h0002,
      PH_METH   = 15'h0004,
      PH_RVER   = 15'h0008,
      PH_RCMD   = 15'h0010,
      PH_RRSV   = 15'h0020,
      PH_RATYP  = 15'h0040,
      PH_UDLEN  = 15'h0080,
      PH_USKIPN = 15'h0100,
      PH_USKIPP = 15'h0200,
      PH_CDLEN  = 15'h0400,
      PH_CADDR  = 15'h0800,
      PH_PHI    = 15'h1000,
      PH_PLO    = 15'h2000,
      PH_DONE   = 15'h4000
   } phase_type;

   localparam logic [8:0] NAME_LIMIT = 9'(MAX_NAME_LEN - 1);

   phase_type     phase_ff, phase_in;
   logic [7:0]    left_ff, left_in;
   logic          noauth_ff, noauth_in;
   logic          udp_ff, udp_in;
   logic          akind_ff, akind_in;
   logic [7:0]    alen_ff, alen_in;
   logic [7:0]    phigh_ff, phigh_in;
   logic          accept;
   logic [7:0]    b;
   logic [7:0]    left_dec;
   logic          noauth_next;
   s5hs_desc_type fail_d;

   function automatic s5hs_desc_type fin_desc(input outcome_type oc, input logic [15:0] fport,
                                              input logic akind, input logic [7:0] alen);
      s5hs_desc_type d;
      d         = '0;
      d.has_fin = 1'b1;
      d.oc      = oc;
      d.fport   = fport;
      d.akind   = akind;
      d.alen    = alen;
      return d;
   endfunction

   function automatic s5hs_desc_type add_reply(input s5hs_desc_type f, input logic [3:0] nrep,
                                               input logic [7:0] code, input logic [31:0] addr,
                                               input logic [15:0] rport);
      s5hs_desc_type d;
      d       = f;
      d.nrep  = nrep;
      d.code  = code;
      d.addr  = addr;
      d.rport = rport;
      return d;
   endfunction

   assign accept      = req_valid && !qstat.full;
   assign req_stall   = qstat.full;
   assign b           = req_rx_byte;
   assign left_dec    = left_ff - 8'd1;
   assign noauth_next = noauth_ff | (b == METHOD_NOAUTH);
   assign fail_d      = fin_desc(OC_FAIL, 16'd0, 1'b0, alen_ff);

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      noauth_in = noauth_ff;
      udp_in    = udp_ff;
      akind_in  = akind_ff;
      alen_in   = alen_ff;
      phigh_in  = phigh_ff;
      push      = 1'b0;
      desc      = fail_d;
      if (accept) begin
         case (req_type)
            REQ_BYTE: begin
               case (phase_ff)
                  PH_GVER: begin
                     if (b != SOCKS_VER) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_GNUM;
                     end
                  end
                  PH_GNUM: begin
                     if (b == 8'd0) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        left_in   = b;
                        noauth_in = 1'b0;
                        phase_in  = PH_METH;
                     end
                  end
                  PH_METH: begin
                     noauth_in = noauth_next;
                     left_in   = left_dec;
                     if (left_dec == 8'd0) begin
                        push = 1'b1;
                        if (noauth_next) begin
                           desc          = add_reply(fail_d, GREET_LEN, METHOD_NOAUTH, 32'd0,
                                                     16'd0);
                           desc.has_fin  = 1'b0;
                           phase_in      = PH_RVER;
                        end else begin
                           desc     = add_reply(fail_d, GREET_LEN, METHOD_NONE, 32'd0, 16'd0);
                           phase_in = PH_DONE;
                        end
                     end
                  end
                  PH_RVER: begin
                     left_in  = {7'd0, b != SOCKS_VER};
                     phase_in = PH_RCMD;
                  end
                  PH_RCMD: begin
                     udp_in = (b == CMD_UDP);
                     if (b != CMD_CONNECT && b != CMD_UDP) begin
                        left_in = left_ff | 8'd2;
                     end
                     phase_in = PH_RRSV;
                  end
                  PH_RRSV: begin
                     phase_in = PH_RATYP;
                  end
                  PH_RATYP: begin
                     left_in = 8'd0;
                     if (left_ff[0]) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else if (left_ff[1]) begin
                        push     = 1'b1;
                        desc     = add_reply(fail_d, REPLY_LEN, REP_BAD_CMD, 32'd0, 16'd0);
                        phase_in = PH_DONE;
                     end else if (udp_ff) begin
                        if (b == ATYP_IPV4) begin
                           left_in  = IPV4_SKIP;
                           phase_in = PH_USKIPP;
                        end else if (b == ATYP_DOMAIN) begin
                           phase_in = PH_UDLEN;
                        end else if (b == ATYP_IPV6) begin
                           left_in  = IPV6_SKIP;
                           phase_in = PH_USKIPP;
                        end else begin
                           push     = 1'b1;
                           phase_in = PH_DONE;
                        end
                     end else begin
                        if (b == ATYP_IPV4) begin
                           akind_in = 1'b0;
                           left_in  = IPV4_LEN;
                           phase_in = PH_CADDR;
                        end else if (b == ATYP_DOMAIN) begin
                           akind_in = 1'b1;
                           phase_in = PH_CDLEN;
                        end else begin
                           push     = 1'b1;
                           desc     = add_reply(fail_d, REPLY_LEN, REP_BAD_ATYP, 32'd0, 16'd0);
                           phase_in = PH_DONE;
                        end
                     end
                  end
                  PH_UDLEN: begin
                     if (b == 8'd0) begin
                        left_in  = PORT_SKIP;
                        phase_in = PH_USKIPP;
                     end else begin
                        left_in  = b;
                        phase_in = PH_USKIPN;
                     end
                  end
                  PH_USKIPN: begin
                     left_in = left_dec;
                     if (left_dec == 8'd0) begin
                        left_in  = PORT_SKIP;
                        phase_in = PH_USKIPP;
                     end
                  end
                  PH_USKIPP: begin
                     left_in = left_dec;
                     if (left_dec == 8'd0) begin
                        push     = 1'b1;
                        desc     = add_reply(fin_desc(OC_UDP, 16'd0, 1'b0, alen_ff), REPLY_LEN,
                                             REP_OK, bind_address, listen_port + 16'd1);
                        phase_in = PH_DONE;
                     end
                  end
                  PH_CDLEN: begin
                     if (b == 8'd0 || {1'b0, b} >= NAME_LIMIT) begin
                        push     = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        left_in  = b;
                        phase_in = PH_CADDR;
                     end
                  end
                  PH_CADDR: begin
                     push          = 1'b1;
                     desc          = '0;
                     desc.has_addr = 1'b1;
                     desc.code     = b;
                     desc.akind    = akind_ff;
                     alen_in       = alen_ff + 8'd1;
                     left_in       = left_dec;
                     if (left_dec == 8'd0) begin
                        phase_in = PH_PHI;
                     end
                  end
                  PH_PHI: begin
                     phigh_in = b;
                     phase_in = PH_PLO;
                  end
                  PH_PLO: begin
                     push     = 1'b1;
                     desc     = add_reply(fin_desc(OC_TCP, {phigh_ff, b}, akind_ff, alen_ff),
                                          REPLY_LEN, REP_OK, bind_address, listen_port);
                     phase_in = PH_DONE;
                  end
                  default: begin
                  end
               endcase
            end
            REQ_LOST: begin
               if (phase_ff != PH_DONE) begin
                  push     = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            REQ_NEW: begin
               phase_in  = PH_GVER;
               left_in   = 8'd0;
               noauth_in = 1'b0;
               udp_in    = 1'b0;
               akind_in  = 1'b0;
               alen_in   = 8'd0;
               phigh_in  = 8'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_GVER;
         left_ff   <= 8'd0;
         noauth_ff <= 1'b0;
         udp_ff    <= 1'b0;
         akind_ff  <= 1'b0;
         alen_ff   <= 8'd0;
         phigh_ff  <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         noauth_ff <= noauth_in;
         udp_ff    <= udp_in;
         akind_ff  <= akind_in;
         alen_ff   <= alen_in;
         phigh_ff  <= phigh_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/s5hs_queue.sv
`default_nettype none
module s5hs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire s5hs_pkg::s5hs_desc_type push_desc,
   input  wire logic                pop,
   output s5hs_pkg::s5hs_desc_type  head,
   output s5hs_pkg::s5hs_qstat_type qstat
);
   import s5hs_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   s5hs_desc_type    entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/s5hs_back.sv
`default_nettype none
module s5hs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire s5hs_pkg::s5hs_desc_type  head,
   input  wire s5hs_pkg::s5hs_qstat_type qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_out_kind,
   output logic [7:0]               rsp_out_byte,
   output logic [1:0]               rsp_outcome,
   output logic [15:0]              rsp_dest_port,
   output logic                     rsp_target_addr_kind,
   output logic [7:0]               rsp_target_addr_len,
   output logic                     rsp_run_last
);
   import s5hs_pkg::*;

   logic [3:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  oc_ff, oc_in;
   logic [15:0] port_ff, port_in;
   logic        akind_ff, akind_in;
   logic [7:0]  alen_ff, alen_in;
   logic        last_ff, last_in;
   logic        emit;
   logic [3:0]  total;
   logic        last;
   logic [7:0]  reply_byte;

   assign total = head.nrep + {3'd0, head.has_fin} + {3'd0, head.has_addr};
   assign last  = (step_ff == total - 4'd1);
   assign emit  = !qstat.empty && (!valid_ff || !rsp_stall);
   assign pop   = emit && last;

   always_comb begin
      case (step_ff)
         4'd0:    reply_byte = SOCKS_VER;
         4'd1:    reply_byte = head.code;
         4'd2:    reply_byte = RSV_BYTE;
         4'd3:    reply_byte = ATYP_IPV4;
         4'd4:    reply_byte = head.addr[31:24];
         4'd5:    reply_byte = head.addr[23:16];
         4'd6:    reply_byte = head.addr[15:8];
         4'd7:    reply_byte = head.addr[7:0];
         4'd8:    reply_byte = head.rport[15:8];
         4'd9:    reply_byte = head.rport[7:0];
         default: reply_byte = 8'd0;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff && rsp_stall;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      oc_in    = oc_ff;
      port_in  = port_ff;
      akind_in = akind_ff;
      alen_in  = alen_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         step_in  = last ? 4'd0 : step_ff + 4'd1;
         last_in  = last;
         oc_in    = OC_FAIL;
         port_in  = 16'd0;
         akind_in = 1'b0;
         alen_in  = 8'd0;
         if (step_ff < head.nrep) begin
            kind_in = KIND_REPLY;
            byte_in = reply_byte;
         end else if (head.has_addr) begin
            kind_in  = KIND_ADDR;
            byte_in  = head.code;
            akind_in = head.akind;
         end else begin
            kind_in  = KIND_FIN;
            byte_in  = 8'd0;
            oc_in    = head.oc;
            port_in  = head.fport;
            akind_in = head.akind;
            alen_in  = head.alen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      oc_ff    <= oc_in;
      port_ff  <= port_in;
      akind_ff <= akind_in;
      alen_ff  <= alen_in;
      last_ff  <= last_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_out_kind         = kind_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_outcome          = oc_ff;
   assign rsp_dest_port        = port_ff;
   assign rsp_target_addr_kind = akind_ff;
   assign rsp_target_addr_len  = alen_ff;
   assign rsp_run_last         = last_ff;

endmodule
`default_nettype wire

### hw/rtl/socks5_server_handshake_top.sv
`default_nettype none
// SOCKS5 server handshake (no-authentication only), one client byte per item.
// The front end takes one item every cycle while its four-entry job queue has
// room; an item either changes only session state or posts one job. The back
// end turns each job into results at one per cycle while not stalled, through a
// registered output stage: an address byte is one result, a greeting answer two
// or three, a full reply with its finish result eleven. Sustained rate is one
// item per cycle for items with no results and is set by the back end's
// one-result-per-cycle drain during reply bursts; req_stall rises only when the
// queue is full. Registers: 0x0 bind_address, 0x4 listen_port (low 16 bits).
module socks5_server_handshake_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_outcome,
   output logic [15:0]      rsp_dest_port,
   output logic             rsp_target_addr_kind,
   output logic [7:0]       rsp_target_addr_len,
   output logic             rsp_run_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import s5hs_pkg::*;

   logic [31:0]    bind_ff, bind_in;
   logic [15:0]    port_ff, port_in;
   logic           csr_wr;
   logic           push;
   logic           pop;
   s5hs_desc_type  push_desc;
   s5hs_desc_type  head;
   s5hs_qstat_type qstat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_PORT) ? {16'd0, port_ff} : bind_ff;

   always_comb begin
      bind_in = bind_ff;
      port_in = port_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_BIND) begin
            bind_in = csr_pwdata;
         end else begin
            port_in = csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bind_ff <= BIND_RESET;
         port_ff <= PORT_RESET;
      end else begin
         bind_ff <= bind_in;
         port_ff <= port_in;
      end
   end

   s5hs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_rx_byte  (req_rx_byte),
      .bind_address (bind_ff),
      .listen_port  (port_ff),
      .qstat        (qstat),
      .push         (push),
      .desc         (push_desc)
   );

   s5hs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   s5hs_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .qstat                (qstat),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_outcome          (rsp_outcome),
      .rsp_dest_port        (rsp_dest_port),
      .rsp_target_addr_kind (rsp_target_addr_kind),
      .rsp_target_addr_len  (rsp_target_addr_len),
      .rsp_run_last         (rsp_run_last)
   );

   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("job queue overflow");

   // a finished result always closes its item
   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_FIN) |-> rsp_run_last)
      else $error("finish result not last");

   // address results stand alone and carry no outcome
   a_addr_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_ADDR) |-> (rsp_run_last && rsp_outcome == OC_FAIL))
      else $error("bad address result");

   // nothing to send while the queue is empty and the output is free
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (qstat.empty && !rsp_valid) |=> !rsp_valid)
      else $error("result without a job");

endmodule
`default_nettype wire

### tb/socks5_server_handshake_checker.sv
`timescale 1ns / 1ps
module socks5_server_handshake_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_out_kind,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic [1:0]  rsp_outcome,
   input  wire logic [15:0] rsp_dest_port,
   input  wire logic        rsp_target_addr_kind,
   input  wire logic [7:0]  rsp_target_addr_len,
   input  wire logic        rsp_run_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending_results
);
   import s5hs_pkg::*;

   typedef enum logic [3:0] {
      ST_GVER, ST_GNUM, ST_METH, ST_RVER, ST_RCMD, ST_RRSV, ST_RATYP,
      ST_UDLEN, ST_USKIPN, ST_USKIPP, ST_CDLEN, ST_CADDR, ST_PHI, ST_PLO, ST_DONE
   } hs_state_type;

   typedef struct packed {
      out_kind_type kind;
      logic [7:0]   data;
      outcome_type  oc;
      logic [15:0]  port;
      logic         akind;
      logic [7:0]   alen;
      logic         last;
   } hs_result_type;

   hs_state_type  hs_state;
   logic [7:0]    count_left;
   logic          noauth_offered;
   logic          udp_cmd;
   logic          bad_version;
   logic          bad_command;
   logic          addr_is_domain;
   logic [7:0]    addr_count;
   logic [7:0]    port_high;
   logic [31:0]   bound_ip;
   logic [15:0]   listen_port;
   hs_result_type due_results[$];
   hs_result_type burst[$];
   hs_result_type want;

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (got_v !== exp_v)
         report_mismatch($sformatf("%s got %0h, want %0h", name, got_v, exp_v));
   endtask

   function automatic void queue_result(input out_kind_type kind, input logic [7:0] data,
                                        input outcome_type oc, input logic [15:0] port,
                                        input logic akind, input logic [7:0] alen);
      hs_result_type r;
      r.kind  = kind;
      r.data  = data;
      r.oc    = oc;
      r.port  = port;
      r.akind = akind;
      r.alen  = alen;
      r.last  = 1'b0;
      burst.push_back(r);
   endfunction

   function automatic void reply_byte(input logic [7:0] b);
      queue_result(KIND_REPLY, b, OC_FAIL, 16'h0000, 1'b0, 8'h00);
   endfunction

   function automatic void reply_full(input logic [7:0] code, input logic [31:0] a,
                                      input logic [15:0] p);
      reply_byte(SOCKS_VER);
      reply_byte(code);
      reply_byte(RSV_BYTE);
      reply_byte(ATYP_IPV4);
      reply_byte(a[31:24]);
      reply_byte(a[23:16]);
      reply_byte(a[15:8]);
      reply_byte(a[7:0]);
      reply_byte(p[15:8]);
      reply_byte(p[7:0]);
   endfunction

   function automatic void finish_session(input outcome_type oc, input logic [15:0] p);
      queue_result(KIND_FIN, 8'h00, oc, p, (oc == OC_TCP) ? addr_is_domain : 1'b0,
                   addr_count);
      hs_state = ST_DONE;
   endfunction

   function automatic void clear_session();
      hs_state       = ST_GVER;
      count_left     = 8'h00;
      noauth_offered = 1'b0;
      udp_cmd        = 1'b0;
      bad_version    = 1'b0;
      bad_command    = 1'b0;
      addr_is_domain = 1'b0;
      addr_count     = 8'h00;
      port_high      = 8'h00;
   endfunction

   task automatic predict_results(input logic [1:0] kind, input logic [7:0] b);
      hs_result_type tail;
      if (kind == REQ_BYTE) begin
         case (hs_state)
            ST_GVER: begin
               if (b != SOCKS_VER) finish_session(OC_FAIL, 16'h0000);
               else hs_state = ST_GNUM;
            end
            ST_GNUM: begin
               if (b == 8'h00) begin
                  finish_session(OC_FAIL, 16'h0000);
               end else begin
                  count_left = b;
                  noauth_offered = 1'b0;
                  hs_state = ST_METH;
               end
            end
            ST_METH: begin
               if (b == METHOD_NOAUTH) noauth_offered = 1'b1;
               count_left--;
               if (count_left == 8'h00) begin
                  reply_byte(SOCKS_VER);
                  if (noauth_offered) begin
                     reply_byte(METHOD_NOAUTH);
                     hs_state = ST_RVER;
                  end else begin
                     reply_byte(METHOD_NONE);
                     finish_session(OC_FAIL, 16'h0000);
                  end
               end
            end
            ST_RVER: begin
               bad_version = (b != SOCKS_VER);
               hs_state = ST_RCMD;
            end
            ST_RCMD: begin
               udp_cmd = (b == CMD_UDP);
               bad_command = (b != CMD_CONNECT && b != CMD_UDP);
               hs_state = ST_RRSV;
            end
            ST_RRSV: hs_state = ST_RATYP;
            ST_RATYP: begin
               count_left = 8'h00;
               if (bad_version) begin
                  finish_session(OC_FAIL, 16'h0000);
               end else if (bad_command) begin
                  reply_full(REP_BAD_CMD, 32'h0, 16'h0);
                  finish_session(OC_FAIL, 16'h0000);
               end else if (udp_cmd) begin
                  if (b == ATYP_IPV4) begin
                     count_left = 8'd6;
                     hs_state = ST_USKIPP;
                  end else if (b == ATYP_DOMAIN) begin
                     hs_state = ST_UDLEN;
                  end else if (b == ATYP_IPV6) begin
                     count_left = 8'd18;
                     hs_state = ST_USKIPP;
                  end else begin
                     finish_session(OC_FAIL, 16'h0000);
                  end
               end else if (b == ATYP_IPV4) begin
                  addr_is_domain = 1'b0;
                  count_left = 8'd4;
                  hs_state = ST_CADDR;
               end else if (b == ATYP_DOMAIN) begin
                  addr_is_domain = 1'b1;
                  hs_state = ST_CDLEN;
               end else begin
                  reply_full(REP_BAD_ATYP, 32'h0, 16'h0);
                  finish_session(OC_FAIL, 16'h0000);
               end
            end
            ST_UDLEN: begin
               if (b == 8'h00) begin
                  count_left = 8'd2;
                  hs_state = ST_USKIPP;
               end else begin
                  count_left = b;
                  hs_state = ST_USKIPN;
               end
            end
            ST_USKIPN: begin
               count_left--;
               if (count_left == 8'h00) begin
                  count_left = 8'd2;
                  hs_state = ST_USKIPP;
               end
            end
            ST_USKIPP: begin
               count_left--;
               if (count_left == 8'h00) begin
                  reply_full(REP_OK, bound_ip, listen_port + 16'd1);
                  finish_session(OC_UDP, 16'h0000);
               end
            end
            ST_CDLEN: begin
               if (b == 8'h00 || b >= MAX_NAME_LEN - 1) begin
                  finish_session(OC_FAIL, 16'h0000);
               end else begin
                  count_left = b;
                  hs_state = ST_CADDR;
               end
            end
            ST_CADDR: begin
               queue_result(KIND_ADDR, b, OC_FAIL, 16'h0000, addr_is_domain, 8'h00);
               addr_count++;
               count_left--;
               if (count_left == 8'h00) hs_state = ST_PHI;
            end
            ST_PHI: begin
               port_high = b;
               hs_state = ST_PLO;
            end
            ST_PLO: begin
               reply_full(REP_OK, bound_ip, listen_port);
               finish_session(OC_TCP, {port_high, b});
            end
            default: ;
         endcase
      end else if (kind == REQ_LOST) begin
         if (hs_state != ST_DONE) finish_session(OC_FAIL, 16'h0000);
      end else if (kind == REQ_NEW) begin
         clear_session();
      end
      if (burst.size() > 0) begin
         tail = burst.pop_back();
         tail.last = 1'b1;
         burst.push_back(tail);
      end
      while (burst.size() > 0) due_results.push_back(burst.pop_front());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bound_ip = BIND_RESET;
         listen_port = PORT_RESET;
         clear_session();
         due_results.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_PORT) listen_port = csr_pwdata[15:0];
            else bound_ip = csr_pwdata;
         end
         if (req_valid && !req_stall) predict_results(req_type, req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch("result with no item waiting");
            end else begin
               want = due_results.pop_front();
               check_field("out_kind", want.kind, rsp_out_kind);
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("outcome", want.oc, rsp_outcome);
               check_field("dest_port", want.port, rsp_dest_port);
               check_field("target_addr_kind", want.akind, rsp_target_addr_kind);
               check_field("target_addr_len", want.alen, rsp_target_addr_len);
               check_field("run_last", want.last, rsp_run_last);
            end
         end
      end
      pending_results = due_results.size();
   end

endmodule

### tb/socks5_server_handshake_top_tb.sv
`timescale 1ns / 1ps
module socks5_server_handshake_top_tb;
   import s5hs_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 420;
   localparam int PHASES       = 6;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 600;

   localparam logic [1:0] REQ_NOOP  = 2'd3;
   localparam logic [2:0] ADDR_BIND = {REG_BIND, 2'b00};
   localparam logic [2:0] ADDR_PORT = {REG_PORT, 2'b00};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } client_item_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_outcome;
   logic [15:0] rsp_dest_port;
   logic        rsp_target_addr_kind;
   logic [7:0]  rsp_target_addr_len;
   logic        rsp_run_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_results;
   int items_sent  = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   int stall_run   = 0;
   bit no_idle     = 1'b0;

   client_item_type session_items[$];

   socks5_server_handshake_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_outcome          (rsp_outcome),
      .rsp_dest_port        (rsp_dest_port),
      .rsp_target_addr_kind (rsp_target_addr_kind),
      .rsp_target_addr_len  (rsp_target_addr_len),
      .rsp_run_last         (rsp_run_last),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   socks5_server_handshake_checker hs_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_outcome          (rsp_outcome),
      .rsp_dest_port        (rsp_dest_port),
      .rsp_target_addr_kind (rsp_target_addr_kind),
      .rsp_target_addr_len  (rsp_target_addr_len),
      .rsp_run_last         (rsp_run_last),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_pready           (csr_pready),
      .fail_count           (fail_count),
      .pending_results      (pending_results)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [7:0] v;
      v = $urandom_range(0, 255);
      return v;
   endfunction

   function automatic logic [7:0] other_byte(input logic [7:0] avoid);
      logic [7:0] v;
      v = rand_byte();
      if (v == avoid) v = v + 8'd1;
      return v;
   endfunction

   function automatic void add_item(input logic [1:0] kind, input logic [7:0] data);
      client_item_type it;
      it.kind = kind;
      it.data = data;
      session_items.push_back(it);
   endfunction

   // receiver side: long hold first, else random runs of stall and no stall
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 2) == 0);
         stall_run = pick_gap();
      end
   end

   task automatic send_item(input client_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= it.kind;
      req_rx_byte <= it.data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (it.kind != REQ_NOOP) items_sent++;
   endtask

   task automatic play_session();
      foreach (session_items[i]) send_item(session_items[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // mostly well-formed sessions with random content, some cut short or noisy
   task automatic build_session();
      int nmeth;
      int pick;
      int noauth_at;
      int dlen;
      int body;
      int cut;
      logic [7:0] cmd;
      logic [7:0] atyp;
      client_item_type noise;
      session_items.delete();
      add_item(REQ_NEW, rand_byte());
      add_item(REQ_BYTE, ($urandom_range(0, 19) == 0) ? other_byte(SOCKS_VER) : SOCKS_VER);
      pick = $urandom_range(0, 99);
      nmeth = (pick < 4) ? 0 : (pick < 85) ? $urandom_range(1, 4) : $urandom_range(5, 16);
      add_item(REQ_BYTE, nmeth[7:0]);
      noauth_at = (nmeth > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, nmeth - 1) : -1;
      for (int i = 0; i < nmeth; i++)
         add_item(REQ_BYTE, (i == noauth_at) ? METHOD_NOAUTH : other_byte(METHOD_NOAUTH));
      add_item(REQ_BYTE, ($urandom_range(0, 24) == 0) ? other_byte(SOCKS_VER) : SOCKS_VER);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         cmd = CMD_CONNECT;
      end else if (pick < 80) begin
         cmd = CMD_UDP;
      end else begin
         do cmd = rand_byte(); while (cmd == CMD_CONNECT || cmd == CMD_UDP);
      end
      add_item(REQ_BYTE, cmd);
      add_item(REQ_BYTE, ($urandom_range(0, 4) == 0) ? rand_byte() : RSV_BYTE);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         atyp = ATYP_IPV4;
      end else if (pick < 75) begin
         atyp = ATYP_DOMAIN;
      end else if (pick < 87) begin
         atyp = ATYP_IPV6;
      end else begin
         do atyp = rand_byte();
         while (atyp == ATYP_IPV4 || atyp == ATYP_DOMAIN || atyp == ATYP_IPV6);
      end
      add_item(REQ_BYTE, atyp);
      if (atyp == ATYP_IPV4) begin
         body = 6;
      end else if (atyp == ATYP_IPV6) begin
         body = (cmd == CMD_UDP) ? 18 : $urandom_range(0, 2);
      end else if (atyp == ATYP_DOMAIN) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) dlen = 0;
         else if (pick < 9) dlen = MAX_NAME_LEN - 1;
         else if (pick < 11) dlen = MAX_NAME_LEN - 2;
         else dlen = $urandom_range(1, 12);
         add_item(REQ_BYTE, dlen[7:0]);
         if (cmd == CMD_UDP || (dlen > 0 && dlen < MAX_NAME_LEN - 1)) body = dlen + 2;
         else body = 2;
      end else begin
         body = $urandom_range(0, 2);
      end
      repeat (body) add_item(REQ_BYTE, rand_byte());
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         cut = $urandom_range(1, session_items.size() - 1);
         while (session_items.size() > cut) void'(session_items.pop_back());
         if (pick < 8) add_item(REQ_LOST, rand_byte());
      end else if (pick < 18) begin
         add_item(REQ_LOST, rand_byte());
      end else if (pick < 22) begin
         add_item(REQ_BYTE, rand_byte());
      end
      if ($urandom_range(0, 99) < 6) begin
         noise.kind = REQ_NOOP;
         noise.data = rand_byte();
         session_items.insert($urandom_range(1, session_items.size()), noise);
      end
   endtask

   initial begin
      int phase_no;
      int start_count;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = REQ_BYTE;
      req_rx_byte = 8'h00;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = ADDR_BIND;
      csr_pwdata  = 32'h0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bad greeting version, then traffic after the session is over
      add_item(REQ_NEW, 8'hFF);
      add_item(REQ_BYTE, 8'h04);
      add_item(REQ_BYTE, 8'hFF);
      add_item(REQ_LOST, 8'h00);
      add_item(REQ_NOOP, 8'hFF);
      // zero method count
      add_item(REQ_NEW, 8'h00);
      add_item(REQ_BYTE, SOCKS_VER);
      add_item(REQ_BYTE, 8'h00);
      // no acceptable method
      add_item(REQ_NEW, 8'h00);
      add_item(REQ_BYTE, SOCKS_VER);
      add_item(REQ_BYTE, 8'h01);
      add_item(REQ_BYTE, METHOD_NONE);
      // connect to an ipv4 target with extreme octets and port
      add_item(REQ_NEW, 8'h00);
      add_item(REQ_BYTE, SOCKS_VER);
      add_item(REQ_BYTE, 8'h01);
      add_item(REQ_BYTE, METHOD_NOAUTH);
      add_item(REQ_BYTE, SOCKS_VER);
      add_item(REQ_BYTE, CMD_CONNECT);
      add_item(REQ_BYTE, RSV_BYTE);
      add_item(REQ_BYTE, ATYP_IPV4);
      add_item(REQ_BYTE, 8'hFF);
      add_item(REQ_BYTE, 8'h00);
      add_item(REQ_BYTE, 8'h00);
      add_item(REQ_BYTE, 8'hFF);
      add_item(REQ_BYTE, 8'hFF);
      add_item(REQ_BYTE, 8'hFF);
      play_session();
      drain();

      start_count = items_sent;
      for (phase_no = 0; phase_no < PHASES; phase_no++) begin
         case (phase_no)
            0: begin
               write_reg(ADDR_BIND, 32'h0000_0000);
               write_reg(ADDR_PORT, 32'h0000_0000);
            end
            1: begin
               write_reg(ADDR_BIND, 32'hFFFF_FFFF);
               write_reg(ADDR_PORT, 32'h0000_FFFF);
            end
            5: begin
               write_reg(ADDR_BIND, $urandom);
               write_reg(ADDR_PORT, 32'hFFFF_0000);
            end
            default: begin
               write_reg(ADDR_BIND, $urandom);
               write_reg(ADDR_PORT, $urandom);
            end
         endcase
         no_idle = (phase_no == 2 || phase_no == 3);
         if (phase_no == 3) hold_cycles = HOLD_CYCLES;
         while (items_sent < start_count + (phase_no + 1) * RANDOM_ITEMS / PHASES) begin
            build_session();
            play_session();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
